### rtl/ffmc_pkg.sv
// Shared types and codes for the flat-field median coefficient block.
`timescale 1ns / 1ps

package ffmc_pkg;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_NOP   = 2'd3;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD      = 2'd1;
	localparam logic [1:0] ST_FEW      = 2'd2;
	localparam logic [1:0] ST_UNLOADED = 2'd3;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] value;
		logic        usable;
		logic [10:0] idx;
	} cmd_t;

endpackage

### rtl/ffmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ffmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/ffmc_front.sv
// Front end: decodes an incoming item into a queue command.
`timescale 1ns / 1ps

module ffmc_front (
	input  logic              valid,
	input  logic [1:0]        kind,
	input  logic [31:0]       sample_value,
	input  logic              bad_channel,
	input  logic [10:0]       channel_index,
	output logic              push,
	output ffmc_pkg::cmd_t    cmd
);

	// A count takes part in the median only if it is good and strictly positive.
	always_comb begin
		cmd.value  = sample_value;
		cmd.idx    = channel_index;
		cmd.usable = !bad_channel && (sample_value != 32'd0) && !sample_value[31];
		unique case (kind)
			ffmc_pkg::KIND_LOAD:  cmd.op = ffmc_pkg::OP_LOAD;
			ffmc_pkg::KIND_READ:  cmd.op = ffmc_pkg::OP_READ;
			ffmc_pkg::KIND_CLEAR: cmd.op = ffmc_pkg::OP_CLEAR;
			default:              cmd.op = ffmc_pkg::OP_CLEAR;
		endcase
		push = valid && (kind != ffmc_pkg::KIND_NOP);
	end

endmodule

### rtl/ffmc_fifo.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module ffmc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ffmc_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output ffmc_pkg::cmd_t rd_cmd
);

	ffmc_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_cmd    = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### rtl/ffmc_calc.sv
// Bit-serial divide, square and square-root unit for coefficient and error.
`timescale 1ns / 1ps

module ffmc_calc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] med,
	input  logic [30:0] cnt,
	output logic        done,
	output logic [31:0] coeff,
	output logic [31:0] err
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_DIV1 = 3'd1;
	localparam logic [2:0] PH_MUL  = 3'd2;
	localparam logic [2:0] PH_DIV2 = 3'd3;
	localparam logic [2:0] PH_SQRT = 3'd4;

	localparam logic [6:0] DIV_LAST = 7'd95;
	localparam logic [6:0] HALF_LAST = 7'd47;

	logic [2:0]  ph_q;
	logic [6:0]  step_q;
	logic [95:0] work_q;
	logic [51:0] rem_q;
	logic [47:0] root_q;
	logic [47:0] q_q;
	logic [30:0] cnt_q;
	logic        done_q;
	logic [31:0] coeff_q;
	logic [31:0] err_q;

	logic [32:0] div_sh;
	logic        div_ge;
	logic [32:0] div_rem;
	logic [95:0] div_work;
	logic [51:0] sq_sh;
	logic [51:0] sq_trial;
	logic        sq_ge;
	logic [51:0] sq_rem;
	logic [47:0] sq_root;

	// Restoring division step: one quotient bit shifts into the work register; the square-root step forms one root bit.
	always_comb begin
		div_sh   = {rem_q[31:0], work_q[95]};
		div_ge   = (div_sh >= {2'b00, cnt_q});
		div_rem  = div_ge ? (div_sh - {2'b00, cnt_q}) : div_sh;
		div_work = {work_q[94:0], div_ge};
		sq_sh    = {rem_q[49:0], work_q[95:94]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = (sq_sh >= sq_trial);
		sq_rem   = sq_ge ? (sq_sh - sq_trial) : sq_sh;
		sq_root  = {root_q[46:0], sq_ge};
	end

	assign done  = done_q;
	assign coeff = coeff_q;
	assign err   = err_q;

	always_ff @(posedge clk) begin
		unique case (ph_q)
			PH_IDLE: begin
				if (start) begin
					work_q <= {49'd0, med, 16'd0};
					rem_q  <= '0;
					cnt_q  <= cnt;
				end
			end
			PH_DIV1: begin
				rem_q <= {19'd0, div_rem};
				if (step_q == DIV_LAST) begin
					q_q     <= div_work[47:0];
					root_q  <= div_work[47:0];
					coeff_q <= (div_work[95:32] != 64'd0) ? 32'hFFFF_FFFF : div_work[31:0];
					work_q  <= '0;
				end else begin
					work_q <= div_work;
				end
			end
			PH_MUL: begin
				work_q <= {work_q[94:0], 1'b0} + (root_q[47] ? {48'd0, q_q} : 96'd0);
				root_q <= {root_q[46:0], 1'b0};
				if (step_q == HALF_LAST) begin
					rem_q <= '0;
				end
			end
			PH_DIV2: begin
				work_q <= div_work;
				if (step_q == DIV_LAST) begin
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					rem_q <= {19'd0, div_rem};
				end
			end
			PH_SQRT: begin
				rem_q  <= sq_rem;
				root_q <= sq_root;
				work_q <= {work_q[93:0], 2'b00};
				if (step_q == HALF_LAST) begin
					err_q <= (sq_root[47:32] != 16'd0) ? 32'hFFFF_FFFF : sq_root[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_SQRT) && (step_q == HALF_LAST);
			unique case (ph_q)
				PH_IDLE: begin
					step_q <= '0;
					if (start) begin
						ph_q <= PH_DIV1;
					end
				end
				PH_DIV1: begin
					if (step_q == DIV_LAST) begin
						ph_q   <= PH_MUL;
						step_q <= '0;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				PH_MUL: begin
					if (step_q == HALF_LAST) begin
						ph_q   <= PH_DIV2;
						step_q <= '0;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				PH_DIV2: begin
					if (step_q == DIV_LAST) begin
						ph_q   <= PH_SQRT;
						step_q <= '0;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				PH_SQRT: begin
					if (step_q == HALF_LAST) begin
						ph_q   <= PH_IDLE;
						step_q <= '0;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				default: begin
					ph_q   <= PH_IDLE;
					step_q <= '0;
				end
			endcase
		end
	end

endmodule

### rtl/ffmc_back.sv
// Back end: sample and sorted stores, insertion sort, read sequencing, result register.
`timescale 1ns / 1ps

module ffmc_back #(
	parameter int CHANNELS = 2048
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  ffmc_pkg::cmd_t cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    coefficient,
	output logic [31:0]    coeff_error,
	output logic [1:0]     status
);

	localparam int AW   = $clog2(CHANNELS);
	localparam int CW   = AW + 1;
	localparam int CMPW = (CW > 11) ? CW : 11;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_RD  = 3'd1;
	localparam logic [2:0] S_INS_CMP = 3'd2;
	localparam logic [2:0] S_INS_FIN = 3'd3;
	localparam logic [2:0] S_RD_WAIT = 3'd4;
	localparam logic [2:0] S_CALC    = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] loaded_q;
	logic [CW-1:0] sorted_q;
	logic [AW-1:0] pos_q;
	logic [31:0]   raw_q;
	logic          out_valid_q;
	logic [31:0]   coefficient_q;
	logic [31:0]   coeff_error_q;
	logic [1:0]    status_q;

	logic          smp_we;
	logic [32:0]   smp_rdata;
	logic          srt_we;
	logic [AW-1:0] srt_waddr;
	logic [31:0]   srt_wdata;
	logic [AW-1:0] srt_raddr;
	logic [31:0]   srt_rdata;
	logic [CMPW-1:0] idx_ext;
	logic [CMPW-1:0] loaded_ext;
	logic          calc_start;
	logic          calc_done;
	logic [31:0]   calc_coeff;
	logic [31:0]   calc_err;

	assign idx_ext    = CMPW'(cmd.idx);
	assign loaded_ext = CMPW'(loaded_q);

	assign pop = (state_q == S_IDLE) && cmd_valid &&
		((cmd.op != ffmc_pkg::OP_READ) || !out_valid_q);

	assign smp_we = pop && (cmd.op == ffmc_pkg::OP_LOAD) && (loaded_q != CW'(CHANNELS));

	always_comb begin
		srt_we    = 1'b0;
		srt_waddr = pos_q;
		srt_wdata = raw_q;
		if ((state_q == S_INS_CMP) && (srt_rdata >= raw_q)) begin
			srt_we    = 1'b1;
			srt_wdata = srt_rdata;
		end else if (state_q == S_INS_FIN) begin
			srt_we = 1'b1;
		end
		srt_raddr = (state_q == S_IDLE) ? sorted_q[CW-1:1] : (pos_q - AW'(1));
	end

	assign calc_start = (state_q == S_RD_WAIT) && smp_rdata[32];

	ffmc_ram #(.WIDTH(33), .DEPTH(CHANNELS)) u_sample_ram (
		.clk   (clk),
		.we    (smp_we),
		.waddr (loaded_q[AW-1:0]),
		.wdata ({cmd.usable, cmd.value}),
		.raddr (idx_ext[AW-1:0]),
		.rdata (smp_rdata)
	);

	ffmc_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_sorted_ram (
		.clk   (clk),
		.we    (srt_we),
		.waddr (srt_waddr),
		.wdata (srt_wdata),
		.raddr (srt_raddr),
		.rdata (srt_rdata)
	);

	ffmc_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start),
		.med    (srt_rdata[30:0]),
		.cnt    (smp_rdata[30:0]),
		.done   (calc_done),
		.coeff  (calc_coeff),
		.err    (calc_err)
	);

	assign out_valid   = out_valid_q;
	assign coefficient = coefficient_q;
	assign coeff_error = coeff_error_q;
	assign status      = status_q;

	always_ff @(posedge clk) begin
		if (smp_we) begin
			raw_q <= cmd.value;
			pos_q <= sorted_q[AW-1:0];
		end else if ((state_q == S_INS_CMP) && (srt_rdata >= raw_q)) begin
			pos_q <= pos_q - AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loaded_q    <= '0;
			sorted_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (cmd.op)
							ffmc_pkg::OP_CLEAR: begin
								loaded_q <= '0;
								sorted_q <= '0;
							end
							ffmc_pkg::OP_LOAD: begin
								if (smp_we) begin
									loaded_q <= loaded_q + CW'(1);
									if (cmd.usable) begin
										state_q <= (sorted_q == '0) ? S_INS_FIN : S_INS_RD;
									end
								end
							end
							ffmc_pkg::OP_READ: begin
								coefficient_q <= '0;
								coeff_error_q <= '0;
								if (idx_ext >= loaded_ext) begin
									status_q    <= ffmc_pkg::ST_UNLOADED;
									out_valid_q <= 1'b1;
								end else if (sorted_q < CW'(2)) begin
									status_q    <= ffmc_pkg::ST_FEW;
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_RD_WAIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if ((srt_rdata >= raw_q) && (pos_q != AW'(1))) begin
						state_q <= S_INS_RD;
					end else begin
						state_q <= S_INS_FIN;
					end
				end
				S_INS_FIN: begin
					sorted_q <= sorted_q + CW'(1);
					state_q  <= S_IDLE;
				end
				S_RD_WAIT: begin
					if (smp_rdata[32]) begin
						state_q <= S_CALC;
					end else begin
						coeff_error_q <= ffmc_pkg::ONE_Q16;
						status_q      <= ffmc_pkg::ST_BAD;
						out_valid_q   <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_CALC: begin
					if (calc_done) begin
						coefficient_q <= calc_coeff;
						coeff_error_q <= calc_err;
						status_q      <= ffmc_pkg::ST_OK;
						out_valid_q   <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/flat_field_median_coefficients.sv
// Flat-field median coefficient block: front end, two-entry queue and back end, one item at a time.
// A clear or a load of an unusable count is taken in directly; a usable load walks down the sorted
// store, moving each count not below it up one place, before it writes its own. A read of an
// unloaded index or with too few points answers straight away, a bad channel once its sample is
// read, and otherwise once the serial unit divides, squares, divides and takes a root. Reset empties
// the queue, both fill counts and the result valid flag; the stores are left as they are, as the counts guard them.
`timescale 1ns / 1ps

module flat_field_median_coefficients #(
	parameter int CHANNELS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic signed [31:0] sample_value,
	input  logic        bad_channel,
	input  logic [10:0] channel_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] coefficient,
	output logic [31:0] coeff_error,
	output logic [1:0]  status
);

	// The front end decodes each item into a command and drops items of no kind.
	// Commands wait in a two-entry queue, so loads and clears can still come in while
	// the back end is busy sorting (until the queue fills) or while a finished result waits to be taken.
	logic           push;
	logic           fifo_full;
	logic           fifo_not_empty;
	logic           pop;
	ffmc_pkg::cmd_t front_cmd;
	ffmc_pkg::cmd_t queue_cmd;

	assign in_stall = fifo_full;

	ffmc_front u_front (
		.valid         (in_valid),
		.kind          (kind),
		.sample_value  (sample_value),
		.bad_channel   (bad_channel),
		.channel_index (channel_index),
		.push          (push),
		.cmd           (front_cmd)
	);

	ffmc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (front_cmd),
		.full      (fifo_full),
		.pop       (pop),
		.not_empty (fifo_not_empty),
		.rd_cmd    (queue_cmd)
	);

	// The back end holds both stores. Good positive counts are placed in the
	// sorted store by walking down from its top, reading and comparing one entry at a time.
	// Besides waiting for an idle back end, a read holds back while an earlier result has not yet been taken.
	ffmc_back #(.CHANNELS(CHANNELS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (fifo_not_empty),
		.cmd         (queue_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.coefficient (coefficient),
		.coeff_error (coeff_error),
		.status      (status)
	);

endmodule
